[hdl/pudf_pkg.sv]
// Shared types and constants for the pose update deadband filter.
// No dependencies; compile first.
`default_nettype none
package pudf_pkg;

  localparam int ENTITIES  = 256;
  localparam int ENT_W     = $clog2(ENTITIES);
  localparam int STAMP_W   = 48;
  localparam int POS_W     = 32;
  localparam int ROT_W     = 16;
  localparam int ENTRY_W   = STAMP_W + 3 * POS_W + 4 * ROT_W;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DAT_W = 48;

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLED     = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DIST_SQ = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_ROT_SQ  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_AGE_US  = 4'd3;

  localparam logic [47:0] RST_MIN_DIST_SQ = 48'd429497;
  localparam logic [30:0] RST_MIN_ROT_SQ  = 31'd107374;
  localparam logic [31:0] RST_MIN_AGE_US  = 32'd30000;

  typedef enum logic [2:0] {
    V_FORWARD = 3'd0,
    V_FIRST   = 3'd1,
    V_EARLY   = 3'd2,
    V_STILL   = 3'd3,
    V_DROP    = 3'd4
  } verdict_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SQR,
    ST_SUM,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic idle;
    logic mul;
    logic sqr;
    logic sum;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic out_full;
  } sts_t;

endpackage
`default_nettype wire

[hdl/pudf_in_if.sv]
// Input channel: one pose update per transaction.
// Depends on pudf_pkg.
`default_nettype none
interface pudf_in_if;
  logic                               valid;
  logic                               ready;
  logic        [pudf_pkg::ENT_W-1:0]   entity;
  logic        [pudf_pkg::STAMP_W-1:0] stamp_us;
  logic signed [pudf_pkg::POS_W-1:0]   pos_x;
  logic signed [pudf_pkg::POS_W-1:0]   pos_y;
  logic signed [pudf_pkg::POS_W-1:0]   pos_z;
  logic signed [pudf_pkg::ROT_W-1:0]   rot_w;
  logic signed [pudf_pkg::ROT_W-1:0]   rot_x;
  logic signed [pudf_pkg::ROT_W-1:0]   rot_y;
  logic signed [pudf_pkg::ROT_W-1:0]   rot_z;

  modport source (output valid, entity, stamp_us, pos_x, pos_y, pos_z,
                  rot_w, rot_x, rot_y, rot_z, input ready);
  modport sink   (input valid, entity, stamp_us, pos_x, pos_y, pos_z,
                  rot_w, rot_x, rot_y, rot_z, output ready);
endinterface
`default_nettype wire

[hdl/pudf_out_if.sv]
// Result channel: entity and verdict per transaction.
// Depends on pudf_pkg.
`default_nettype none
interface pudf_out_if;
  logic                       valid;
  logic                       ready;
  logic [pudf_pkg::ENT_W-1:0] entity_out;
  logic [2:0]                 verdict;

  modport source (output valid, entity_out, verdict, input ready);
  modport sink   (input valid, entity_out, verdict, output ready);
endinterface
`default_nettype wire

[hdl/pudf_cfg_if.sv]
// Configuration write channel: register index and data.
// Depends on pudf_pkg.
`default_nettype none
interface pudf_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [pudf_pkg::CFG_IDX_W-1:0] index;
  logic [pudf_pkg::CFG_DAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

[hdl/pudf_ctrl.sv]
// Sequencing state machine for the filter.
// Depends on pudf_pkg.
`default_nettype none
module pudf_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  pudf_pkg::sts_t      sts,
  output pudf_pkg::cmd_t      cmd
);

  pudf_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pudf_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pudf_pkg::ST_IDLE: if (sts.in_valid) state_nxt = pudf_pkg::ST_MUL;
      pudf_pkg::ST_MUL:  state_nxt = pudf_pkg::ST_SQR;
      pudf_pkg::ST_SQR:  state_nxt = pudf_pkg::ST_SUM;
      pudf_pkg::ST_SUM:  state_nxt = pudf_pkg::ST_DONE;
      pudf_pkg::ST_DONE: if (!sts.out_full) state_nxt = pudf_pkg::ST_IDLE;
      default:           state_nxt = pudf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      pudf_pkg::ST_IDLE: cmd.idle   = 1'b1;
      pudf_pkg::ST_MUL:  cmd.mul    = 1'b1;
      pudf_pkg::ST_SQR:  cmd.sqr    = 1'b1;
      pudf_pkg::ST_SUM:  cmd.sum    = 1'b1;
      pudf_pkg::ST_DONE: cmd.finish = !sts.out_full;
      default:           cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

[hdl/pudf_dp.sv]
// Datapath: config registers, pose table, difference and quaternion math,
// result register. Depends on pudf_pkg and the channel interfaces.
`default_nettype none
module pudf_dp (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  pudf_pkg::cmd_t cmd,
  output pudf_pkg::sts_t sts,
  pudf_in_if.sink       in_if,
  pudf_out_if.source    out_if,
  pudf_cfg_if.sink      cfg_if
);

  logic        en_r;
  logic [47:0] min_dist_r;
  logic [30:0] min_rot_r;
  logic [31:0] min_age_r;

  logic [pudf_pkg::ENTRY_W-1:0] mem [pudf_pkg::ENTITIES];
  logic [pudf_pkg::ENTITIES-1:0] seen_r;

  logic [pudf_pkg::ENT_W-1:0]   ent_r;
  logic [pudf_pkg::STAMP_W-1:0] stamp_r;
  logic signed [31:0] px_r, py_r, pz_r;
  logic signed [15:0] rw_r, rx_r, ry_r, rz_r;
  logic seen_hit_r, en_hit_r;
  logic [pudf_pkg::ENTRY_W-1:0] old_r;

  logic signed [47:0] o_stamp;
  logic signed [31:0] o_px, o_py, o_pz;
  logic signed [15:0] o_w, o_x, o_y, o_z;

  logic signed [48:0] dt_r;
  logic [32:0] dm_r [3];
  logic signed [31:0] prod_r [12];
  logic [47:0] sq_r [3];
  logic big_r;
  logic signed [19:0] q_r [3];
  logic [49:0] dsum_r;
  logic [41:0] qsq_r;
  logic early_r;

  logic out_valid_r;
  logic [pudf_pkg::ENT_W-1:0] out_ent_r;
  pudf_pkg::verdict_t out_verdict_r, verdict;

  logic capture;
  logic store;
  logic moved, rotated;

  assign capture = in_if.valid && in_if.ready;
  assign in_if.ready = cmd.idle;
  assign cfg_if.ready = 1'b1;
  assign sts.in_valid = in_if.valid;
  assign sts.out_full = out_valid_r && !out_if.ready;

  assign o_stamp = $signed(old_r[207:160]);
  assign o_px = $signed(old_r[159:128]);
  assign o_py = $signed(old_r[127:96]);
  assign o_pz = $signed(old_r[95:64]);
  assign o_w  = $signed(old_r[63:48]);
  assign o_x  = $signed(old_r[47:32]);
  assign o_y  = $signed(old_r[31:16]);
  assign o_z  = $signed(old_r[15:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r       <= 1'b0;
      min_dist_r <= pudf_pkg::RST_MIN_DIST_SQ;
      min_rot_r  <= pudf_pkg::RST_MIN_ROT_SQ;
      min_age_r  <= pudf_pkg::RST_MIN_AGE_US;
    end else if (cfg_if.valid) begin
      unique case (cfg_if.index)
        pudf_pkg::CFG_ENABLED:     en_r       <= cfg_if.data[0];
        pudf_pkg::CFG_MIN_DIST_SQ: min_dist_r <= cfg_if.data[47:0];
        pudf_pkg::CFG_MIN_ROT_SQ:  min_rot_r  <= cfg_if.data[30:0];
        pudf_pkg::CFG_MIN_AGE_US:  min_age_r  <= cfg_if.data[31:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (capture) begin
      old_r <= mem[in_if.entity];
    end
    if (cmd.finish && store) begin
      mem[ent_r] <= {stamp_r, px_r, py_r, pz_r, rw_r, rx_r, ry_r, rz_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= '0;
    end else if (cmd.finish && store) begin
      seen_r[ent_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (capture) begin
      ent_r      <= in_if.entity;
      stamp_r    <= in_if.stamp_us;
      px_r       <= in_if.pos_x;
      py_r       <= in_if.pos_y;
      pz_r       <= in_if.pos_z;
      rw_r       <= in_if.rot_w;
      rx_r       <= in_if.rot_x;
      ry_r       <= in_if.rot_y;
      rz_r       <= in_if.rot_z;
      seen_hit_r <= seen_r[in_if.entity];
      en_hit_r   <= en_r;
    end
  end

  // mul stage: time and position differences, quaternion partial products
  always_ff @(posedge clk) begin
    logic signed [32:0] d [3];
    if (cmd.mul) begin
      dt_r <= $signed({1'b0, stamp_r}) - $signed({1'b0, o_stamp});
      d[0] = {px_r[31], px_r} - {o_px[31], o_px};
      d[1] = {py_r[31], py_r} - {o_py[31], o_py};
      d[2] = {pz_r[31], pz_r} - {o_pz[31], o_pz};
      for (int i = 0; i < 3; i++) begin
        dm_r[i] <= d[i][32] ? 33'(-d[i]) : 33'(d[i]);
      end
      prod_r[0]  <= rw_r * o_x;
      prod_r[1]  <= rx_r * o_w;
      prod_r[2]  <= ry_r * o_z;
      prod_r[3]  <= rz_r * o_y;
      prod_r[4]  <= rw_r * o_y;
      prod_r[5]  <= rx_r * o_z;
      prod_r[6]  <= ry_r * o_w;
      prod_r[7]  <= rz_r * o_x;
      prod_r[8]  <= rw_r * o_z;
      prod_r[9]  <= rx_r * o_y;
      prod_r[10] <= ry_r * o_x;
      prod_r[11] <= rz_r * o_w;
    end
  end

  // sqr stage: position squares, rounded quaternion vector part
  always_ff @(posedge clk) begin
    logic signed [33:0] s [3];
    logic signed [34:0] t;
    if (cmd.sqr) begin
      for (int i = 0; i < 3; i++) begin
        sq_r[i] <= dm_r[i][23:0] * dm_r[i][23:0];
      end
      big_r <= (dm_r[0][32:24] != '0) || (dm_r[1][32:24] != '0) ||
               (dm_r[2][32:24] != '0);
      s[0] = 34'(prod_r[0]) - 34'(prod_r[1]) - 34'(prod_r[2]) + 34'(prod_r[3]);
      s[1] = 34'(prod_r[4]) + 34'(prod_r[5]) - 34'(prod_r[6]) - 34'(prod_r[7]);
      s[2] = 34'(prod_r[8]) - 34'(prod_r[9]) + 34'(prod_r[10]) - 34'(prod_r[11]);
      for (int i = 0; i < 3; i++) begin
        t = 35'(s[i]) + 35'sd16384;
        q_r[i] <= t[34:15];
      end
    end
  end

  // sum stage: squared norms and age check
  always_ff @(posedge clk) begin
    logic signed [39:0] qq [3];
    if (cmd.sum) begin
      for (int i = 0; i < 3; i++) begin
        qq[i] = q_r[i] * q_r[i];
      end
      dsum_r <= 50'(sq_r[0]) + 50'(sq_r[1]) + 50'(sq_r[2]);
      qsq_r  <= 42'($unsigned(qq[0])) + 42'($unsigned(qq[1])) +
                42'($unsigned(qq[2]));
      early_r <= !dt_r[48] && (dt_r != '0) && (dt_r[47:0] < {16'd0, min_age_r});
    end
  end

  always_comb begin
    moved   = big_r || (dsum_r > {2'd0, min_dist_r});
    rotated = qsq_r > {11'd0, min_rot_r};
    priority if (!en_hit_r) begin
      verdict = pudf_pkg::V_DROP;
    end else if (!seen_hit_r) begin
      verdict = pudf_pkg::V_FIRST;
    end else if (early_r) begin
      verdict = pudf_pkg::V_EARLY;
    end else if (!moved && !rotated) begin
      verdict = pudf_pkg::V_STILL;
    end else begin
      verdict = pudf_pkg::V_FORWARD;
    end
    store = (verdict == pudf_pkg::V_FIRST) || (verdict == pudf_pkg::V_FORWARD);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_ent_r     <= ent_r;
      out_verdict_r <= verdict;
    end
  end

  assign out_if.valid      = out_valid_r;
  assign out_if.entity_out = out_ent_r;
  assign out_if.verdict    = out_verdict_r;

endmodule
`default_nettype wire

[hdl/pose_update_deadband_filter.sv]
// Top level of the pose update deadband filter.
// Depends on pudf_pkg, the channel interfaces, pudf_ctrl and pudf_dp.
`default_nettype none
// Each accepted update goes through table read, difference and product
// stage, square and rounding stage, sum stage, then decision with table
// write, from input transaction to result. The pose table is read once and
// written at most once per update, and the next update is accepted once
// the result is in the output register, so a stalled result holds the block
// only when a second result is ready behind it. Valid marks clear at reset.
module pose_update_deadband_filter (
  input  wire logic  clk,
  input  wire logic  rst_n,
  pudf_in_if.sink    in_if,
  pudf_out_if.source out_if,
  pudf_cfg_if.sink   cfg_if
);

  pudf_pkg::cmd_t cmd;
  pudf_pkg::sts_t sts;

  pudf_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  pudf_dp u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (cmd),
    .sts    (sts),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

endmodule
`default_nettype wire

[hdl/pudf_checker.sv]
// Port-level checks for the filter, bound to the top level.
// Depends on pose_update_deadband_filter.
`default_nettype none
module pudf_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [2:0] verdict
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted on consecutive cycles");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("bad state after reset");

  a_verdict_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> verdict == pudf_pkg::V_FORWARD || verdict == pudf_pkg::V_FIRST ||
                  verdict == pudf_pkg::V_EARLY || verdict == pudf_pkg::V_STILL ||
                  verdict == pudf_pkg::V_DROP)
    else $error("verdict out of range");

endmodule

bind pose_update_deadband_filter pudf_checker u_pudf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_if.valid),
  .in_ready  (in_if.ready),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .verdict   (out_if.verdict)
);
`default_nettype wire

[dv/pudf_test_pkg.sv]
// Shared transaction types for the deadband filter testbench.
// Depends on pudf_pkg.
`timescale 1ns / 100ps
package pudf_test_pkg;
  import pudf_pkg::*;

  typedef struct packed {
    logic [ENT_W-1:0]          entity;
    logic [STAMP_W-1:0]        stamp_us;
    logic signed [POS_W-1:0]   pos_x;
    logic signed [POS_W-1:0]   pos_y;
    logic signed [POS_W-1:0]   pos_z;
    logic signed [ROT_W-1:0]   rot_w;
    logic signed [ROT_W-1:0]   rot_x;
    logic signed [ROT_W-1:0]   rot_y;
    logic signed [ROT_W-1:0]   rot_z;
  } pose_upd_t;
endpackage

[dv/pudf_verdict_checker.sv]
// Watches the pose update channels, predicts each verdict and compares.
// Depends on pudf_pkg, pudf_test_pkg and the channel interfaces.
`timescale 1ns / 100ps
module pudf_verdict_checker (
  input  logic     clk,
  input  logic     rst_n,
  pudf_in_if       in_if,
  pudf_out_if      out_if,
  pudf_cfg_if      cfg_if,
  output int       fail_count,
  output int       pending_verdicts,
  output int       verdicts_seen,
  output int       forwarded_seen
);
  import pudf_pkg::*;
  import pudf_test_pkg::*;

  typedef struct packed {
    logic [ENT_W-1:0] entity;
    verdict_t         verdict;
  } verdict_rec_t;

  logic                   flt_enabled;
  logic [47:0]            flt_dist_sq;
  logic [30:0]            flt_rot_sq;
  logic [31:0]            flt_age_us;
  logic                   seen_tbl  [ENTITIES];
  logic [STAMP_W-1:0]     stamp_tbl [ENTITIES];
  pose_upd_t              pose_tbl  [ENTITIES];
  verdict_rec_t           verdict_q [$];

  function automatic longint round_q15(longint v);
    longint t;
    t = v + 16384;
    return t >>> 15;
  endfunction

  function automatic verdict_t judge_update(pose_upd_t u);
    pose_upd_t o;
    longint d, dd, qx, qy, qz;
    longint unsigned sum, a, rsq;
    logic moved;
    longint cw, cx, cy, cz, ow, ox, oy, oz;
    if (!flt_enabled) return V_DROP;
    if (!seen_tbl[u.entity]) return V_FIRST;
    o = pose_tbl[u.entity];
    d = longint'({16'd0, u.stamp_us}) - longint'({16'd0, stamp_tbl[u.entity]});
    if (d > 0 && d < longint'({32'd0, flt_age_us})) return V_EARLY;
    moved = 0;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      case (i)
        0: dd = longint'(u.pos_x) - longint'(o.pos_x);
        1: dd = longint'(u.pos_y) - longint'(o.pos_y);
        default: dd = longint'(u.pos_z) - longint'(o.pos_z);
      endcase
      a = (dd < 0) ? -dd : dd;
      if (a >= (64'd1 << 24)) moved = 1;
      else sum += a * a;
    end
    if (sum > {16'd0, flt_dist_sq}) moved = 1;
    cw = u.rot_w; cx = u.rot_x; cy = u.rot_y; cz = u.rot_z;
    ow = o.rot_w; ox = o.rot_x; oy = o.rot_y; oz = o.rot_z;
    qx = round_q15(cw * ox - cx * ow - cy * oz + cz * oy);
    qy = round_q15(cw * oy + cx * oz - cy * ow - cz * ox);
    qz = round_q15(cw * oz - cx * oy + cy * ox - cz * ow);
    rsq = qx * qx + qy * qy + qz * qz;
    if (!moved && !(rsq > {33'd0, flt_rot_sq})) return V_STILL;
    return V_FORWARD;
  endfunction

  always @(posedge clk) begin
    pose_upd_t    u;
    verdict_rec_t r;
    if (!rst_n) begin
      flt_enabled <= 1'b0;
      flt_dist_sq <= RST_MIN_DIST_SQ;
      flt_rot_sq  <= RST_MIN_ROT_SQ;
      flt_age_us  <= RST_MIN_AGE_US;
      for (int i = 0; i < ENTITIES; i++) seen_tbl[i] <= 1'b0;
      verdict_q.delete();
      fail_count <= 0;
      verdicts_seen <= 0;
      forwarded_seen <= 0;
    end else begin
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.index)
          CFG_ENABLED:     flt_enabled <= cfg_if.data[0];
          CFG_MIN_DIST_SQ: flt_dist_sq <= cfg_if.data[47:0];
          CFG_MIN_ROT_SQ:  flt_rot_sq  <= cfg_if.data[30:0];
          CFG_MIN_AGE_US:  flt_age_us  <= cfg_if.data[31:0];
          default: ;
        endcase
      end
      if (in_if.valid && in_if.ready) begin
        u = '{in_if.entity, in_if.stamp_us, in_if.pos_x, in_if.pos_y, in_if.pos_z,
              in_if.rot_w, in_if.rot_x, in_if.rot_y, in_if.rot_z};
        r.entity  = u.entity;
        r.verdict = judge_update(u);
        if (r.verdict == V_FIRST || r.verdict == V_FORWARD) begin
          seen_tbl[u.entity]  <= 1'b1;
          stamp_tbl[u.entity] <= u.stamp_us;
          pose_tbl[u.entity]  <= u;
        end
        verdict_q = {verdict_q, r};
      end
      if (out_if.valid && out_if.ready) begin
        verdicts_seen <= verdicts_seen + 1;
        if (out_if.verdict == V_FORWARD) forwarded_seen <= forwarded_seen + 1;
        if (verdict_q.size() == 0) begin
          $error("unexpected transaction: entity_out %0d verdict %0d",
                 out_if.entity_out, out_if.verdict);
          fail_count <= fail_count + 1;
        end else begin
          r = verdict_q.pop_front();
          if (out_if.entity_out !== r.entity) begin
            $error("entity_out: expected %0d, actual %0d", r.entity, out_if.entity_out);
            fail_count <= fail_count + 1;
          end else if (out_if.verdict !== r.verdict) begin
            $error("verdict: expected %0d, actual %0d", r.verdict, out_if.verdict);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

  assign pending_verdicts = verdict_q.size();
endmodule

[dv/pose_update_deadband_filter_test.sv]
// Stimulus and verdict for the pose update deadband filter.
// Depends on pudf_pkg, pudf_test_pkg, the interfaces and pudf_verdict_checker.
`timescale 1ns / 100ps
module pose_update_deadband_filter_test;
  import pudf_pkg::*;
  import pudf_test_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   fail_count, pending_verdicts, verdicts_seen, forwarded_seen;
  int   send_idle_pct = 0;
  int   stall_pct = 0;
  bit   hold_off = 0;
  bit   timed_out = 0;
  int   idle_cycles = 0;
  int   updates_sent = 0;
  pose_upd_t    fleet [ENTITIES];
  logic [47:0]  clock_us;

  pudf_in_if  in_if ();
  pudf_out_if out_if ();
  pudf_cfg_if cfg_if ();

  pose_update_deadband_filter dut (
    .clk(clk), .rst_n(rst_n), .in_if(in_if), .out_if(out_if), .cfg_if(cfg_if)
  );

  pudf_verdict_checker checker_i (
    .clk(clk), .rst_n(rst_n), .in_if(in_if), .out_if(out_if), .cfg_if(cfg_if),
    .fail_count(fail_count), .pending_verdicts(pending_verdicts),
    .verdicts_seen(verdicts_seen), .forwarded_seen(forwarded_seen)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    in_if.valid = 1'b0;
    in_if.entity = '0;
    in_if.stamp_us = '0;
    in_if.pos_x = '0;
    in_if.pos_y = '0;
    in_if.pos_z = '0;
    in_if.rot_w = '0;
    in_if.rot_x = '0;
    in_if.rot_y = '0;
    in_if.rot_z = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= !hold_off && ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
      timed_out = 1;
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic drain_block();
    while (pending_verdicts != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic offer_update(pose_upd_t u);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid    <= 1'b1;
    in_if.entity   <= u.entity;
    in_if.stamp_us <= u.stamp_us;
    in_if.pos_x    <= u.pos_x;
    in_if.pos_y    <= u.pos_y;
    in_if.pos_z    <= u.pos_z;
    in_if.rot_w    <= u.rot_w;
    in_if.rot_x    <= u.rot_x;
    in_if.rot_y    <= u.rot_y;
    in_if.rot_z    <= u.rot_z;
    do @(posedge clk); while (!in_if.ready);
    updates_sent++;
  endtask

  task automatic end_burst();
    in_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic pose_upd_t noise_update();
    pose_upd_t u;
    u = pose_upd_t'({$urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom, $urandom, $urandom});
    return u;
  endfunction

  // Advance a tracked entity by a small or large step so thresholds are straddled.
  function automatic pose_upd_t step_entity(logic [ENT_W-1:0] e);
    pose_upd_t u;
    int span;
    u = fleet[e];
    u.entity = e;
    span = ($urandom_range(3) == 0) ? 2000000 : 1200;
    u.pos_x += $signed($urandom_range(2 * span)) - span;
    u.pos_y += $signed($urandom_range(2 * span)) - span;
    u.pos_z += $signed($urandom_range(2 * span)) - span;
    if ($urandom_range(2) == 0) begin
      u.rot_w = 16'($urandom); u.rot_x = 16'($urandom);
      u.rot_y = 16'($urandom); u.rot_z = 16'($urandom);
    end else begin
      u.rot_x += 16'($signed($urandom_range(400)) - 200);
      u.rot_y += 16'($signed($urandom_range(400)) - 200);
    end
    case ($urandom_range(9))
      0: u.stamp_us = clock_us - $urandom_range(50000);
      1: u.stamp_us = fleet[e].stamp_us;
      2, 3: u.stamp_us = fleet[e].stamp_us + $urandom_range(29999);
      default: u.stamp_us = fleet[e].stamp_us + $urandom_range(200000, 30000);
    endcase
    clock_us = (u.stamp_us > clock_us) ? u.stamp_us : clock_us;
    fleet[e] = u;
    return u;
  endfunction

  task automatic random_phase(int n, int idle_pct, int stall_p);
    pose_upd_t u;
    send_idle_pct = idle_pct;
    stall_pct = stall_p;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0) u = noise_update();
      else u = step_entity(ENT_W'($urandom_range(15) == 0 ? $urandom_range(255) :
                                                            $urandom_range(11)));
      offer_update(u);
      if ($urandom_range(19) == 0) end_burst();
    end
    end_burst();
    drain_block();
  endtask

  initial begin
    pose_upd_t u;
    for (int i = 0; i < ENTITIES; i++) begin
      fleet[i] = '0;
      fleet[i].rot_w = 16'sd32767;
    end
    clock_us = 48'd1000;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Disabled at reset: updates drop.
    u = '0; u.entity = 8'd3;
    offer_update(u);
    end_burst();
    drain_block();
    write_reg(CFG_ENABLED, 48'd1);
    write_reg(4'd9, 48'hFFFF_FFFF_FFFF);

    // First sighting, then early, equal stamp, backward time, still, moved, rotated.
    u = '0; u.entity = 8'd255; u.stamp_us = 48'd100000; u.rot_w = 16'sd32767;
    offer_update(u);
    u.stamp_us = 48'd100001; offer_update(u);
    u.stamp_us = 48'd100000; offer_update(u);
    u.stamp_us = 48'd50;     offer_update(u);
    u.pos_x = 32'sd600;      offer_update(u);
    u.pos_x = 32'sh0100_0000; offer_update(u);
    u.pos_x = 32'sh7FFF_FFFF; u.stamp_us = 48'hFFFF_FFFF_FFFF; offer_update(u);
    u.pos_x = 32'sh8000_0000; u.pos_y = 32'sh8000_0000; u.pos_z = 32'sh7FFF_FFFF;
    u.stamp_us = 48'd0; offer_update(u);
    u.rot_w = 16'sh8000; u.rot_x = 16'sh8000; u.rot_y = 16'sh7FFF; u.rot_z = 16'sh8000;
    offer_update(u);
    u.rot_w = 16'sh7FFF; u.rot_x = 16'sh7FFF; u.rot_y = 16'sh8000; u.rot_z = 16'sh7FFF;
    offer_update(u);
    u.rot_x = 16'sh7FF0; offer_update(u);
    u.entity = 8'd0; offer_update(u); offer_update(u);
    end_burst();
    drain_block();

    write_reg(CFG_MIN_DIST_SQ, 48'hFFFF_FFFF_FFFF);
    write_reg(CFG_MIN_ROT_SQ, 48'd1073741824);
    write_reg(CFG_MIN_AGE_US, 48'd0);
    u.entity = 8'd0; u.pos_x += 32'sd5; offer_update(u);
    u.pos_x = 32'sd0; offer_update(u);
    end_burst();
    drain_block();
    write_reg(CFG_MIN_DIST_SQ, 48'd0);
    write_reg(CFG_MIN_ROT_SQ, 48'd0);
    write_reg(CFG_MIN_AGE_US, 48'hFFFF_FFFF);
    u.stamp_us = 48'd5; offer_update(u);
    u.stamp_us = 48'h8000_0000_0000; offer_update(u);
    end_burst();
    drain_block();

    write_reg(CFG_MIN_DIST_SQ, {16'd0, RST_MIN_DIST_SQ[31:0]});
    write_reg(CFG_MIN_ROT_SQ, {17'd0, RST_MIN_ROT_SQ});
    write_reg(CFG_MIN_AGE_US, {16'd0, RST_MIN_AGE_US});
    random_phase(350, 0, 0);
    random_phase(300, 74, 0);
    random_phase(300, 0, 74);
    random_phase(250, 16, 16);

    // Hold off the receiver while updates keep coming so the block backs up.
    fork
      begin
        hold_off = 1;
        repeat (300) @(posedge clk);
        hold_off = 0;
      end
      random_phase(40, 0, 0);
    join

    write_reg(CFG_ENABLED, 48'd0);
    random_phase(40, 16, 16);
    write_reg(CFG_ENABLED, 48'd1);
    write_reg(CFG_MIN_DIST_SQ, 48'd40000000);
    write_reg(CFG_MIN_ROT_SQ, 48'd4000000);
    write_reg(CFG_MIN_AGE_US, 48'd100000);
    random_phase(150, 0, 0);

    $display("Ran %0d pose updates, %0d verdicts checked, %0d forwarded.",
             updates_sent, verdicts_seen, forwarded_seen);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
